[hdl/bqb_pkg.sv]
// Shared types, constants and helpers for the Bayer 2x2 binning core.
// No dependencies; imported by every module of the block.
package bqb_pkg;

    localparam int DEF_MAX_LINE_WIDTH = 4096;

    // configuration register indexes
    localparam logic [1:0] CFG_PATTERN = 2'd0;
    localparam logic [1:0] CFG_DEPTH   = 2'd1;
    localparam logic [1:0] CFG_WIDTH   = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST = 13'd4096;

    // mosaic arrangements
    localparam logic [1:0] PAT_RGGB = 2'd0;
    localparam logic [1:0] PAT_BGGR = 2'd1;
    localparam logic [1:0] PAT_GRBG = 2'd2;
    localparam logic [1:0] PAT_GBRG = 2'd3;

    localparam logic [7:0]  CLIP_8    = 8'd255;
    localparam logic [15:0] CLIP_16   = 16'd65528;
    localparam int          HI_SHIFT  = 8;

    // line store entry: bit 8 clip, bits 7:0 reduced sample
    typedef struct packed {
        logic       clip;
        logic [7:0] val;
    } t_entry;

    // per-sample control handed from the scheduler to the combine stage
    typedef struct packed {
        logic blk;   // lower row, inside a complete block
        logic odd;   // right column of the block
        logic eor;   // last block of the binned row
    } t_ctl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       clipped;
    } t_pix;

    function automatic logic [7:0] mean2(input logic [7:0] x, input logic [7:0] y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y} + 9'd1;
        return s[8:1];
    endfunction

    // a upper-left, b upper-right, c lower-left, d lower-right
    function automatic t_pix combine(input logic [1:0] pat, input t_entry a,
                                     input t_entry b, input t_entry c,
                                     input t_entry d);
        t_pix p;
        p.clipped = a.clip | b.clip | c.clip | d.clip;
        unique case (pat)
            PAT_BGGR: begin
                p.red = d.val; p.blue = a.val; p.green = mean2(b.val, c.val);
            end
            PAT_GRBG: begin
                p.red = b.val; p.blue = c.val; p.green = mean2(a.val, d.val);
            end
            PAT_GBRG: begin
                p.red = c.val; p.blue = b.val; p.green = mean2(a.val, d.val);
            end
            default: begin
                p.red = a.val; p.blue = d.val; p.green = mean2(b.val, c.val);
            end
        endcase
        return p;
    endfunction

endpackage

[hdl/bqb_line_store.sv]
// Upper-row line store: one write and one registered read per cycle.
// Depends on bqb_pkg for the entry type.
module bqb_line_store #(
    parameter int MAX_LINE_WIDTH = bqb_pkg::DEF_MAX_LINE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(MAX_LINE_WIDTH)-1:0] i_waddr,
    input  bqb_pkg::t_entry                   i_wdata,
    input  logic                              i_re,
    input  logic [$clog2(MAX_LINE_WIDTH)-1:0] i_raddr,
    output bqb_pkg::t_entry                   o_rdata
);
    import bqb_pkg::*;

    t_entry mem [MAX_LINE_WIDTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bqb_sched.sv]
// Column/row tracking and sample reduction; issues line store accesses.
// Depends on bqb_pkg.
module bqb_sched #(
    parameter int MAX_LINE_WIDTH = bqb_pkg::DEF_MAX_LINE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [15:0]                       i_raw_sample,
    input  logic                              i_start_of_frame,
    input  logic                              i_depth,
    input  logic [bqb_pkg::CFG_DATA_W-1:0]    i_line_width,
    output logic [$clog2(MAX_LINE_WIDTH)-1:0] o_addr,
    output logic                              o_we,
    output logic                              o_re,
    output bqb_pkg::t_entry                   o_entry,
    output bqb_pkg::t_ctl                     o_ctl
);
    import bqb_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE_WIDTH);
    localparam int WID_W = $clog2(MAX_LINE_WIDTH + 1);
    localparam int LW_W  = (WID_W > CFG_DATA_W) ? WID_W : CFG_DATA_W;
    localparam logic [LW_W-1:0] W_MAX = LW_W'(MAX_LINE_WIDTH);
    localparam logic [LW_W-1:0] W_MIN = LW_W'(2);

    logic [CNT_W-1:0] r_col, n_col;
    logic             r_lower, n_lower;

    logic [LW_W-1:0] lw_ext, w, even_w, col0, col, col_inc;
    logic            lower, last;

    always_comb begin
        lw_ext = LW_W'(i_line_width);
        if (lw_ext < W_MIN) begin
            w = W_MIN;
        end else if (lw_ext > W_MAX) begin
            w = W_MAX;
        end else begin
            w = lw_ext;
        end
        even_w  = {w[LW_W-1:1], 1'b0};
        col0    = i_start_of_frame ? '0 : LW_W'(r_col);
        lower   = i_start_of_frame ? 1'b0 : r_lower;
        // stale column after a width change wraps to zero
        col     = (col0 >= w) ? '0 : col0;
        col_inc = col + LW_W'(1);
        last    = (col_inc >= w);
        n_col   = last ? '0 : col_inc[CNT_W-1:0];
        n_lower = last ? ~lower : lower;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_lower <= 1'b0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_lower <= n_lower;
        end
    end

    always_comb begin
        if (i_depth) begin
            o_entry.val  = i_raw_sample[HI_SHIFT +: 8];
            o_entry.clip = (i_raw_sample >= CLIP_16);
        end else begin
            o_entry.val  = i_raw_sample[7:0];
            o_entry.clip = (i_raw_sample[7:0] >= CLIP_8);
        end
        o_ctl.blk = lower && (col < even_w);
        o_ctl.odd = col[0];
        o_ctl.eor = (col == even_w - LW_W'(1));
    end

    assign o_addr = col[CNT_W-1:0];
    assign o_we   = i_accept && !lower;
    assign o_re   = i_accept && lower && (col < even_w);

endmodule

[hdl/bayer_quad_bin_to_rgb_core.sv]
// Bayer 2x2 superpixel binning core: raw mosaic samples in, one RGB word
// per 2x2 block out. Top level; uses bqb_pkg, bqb_sched and bqb_line_store.
//
// Takes one raw sample word per clock while o_ready is high. Upper-row samples
// are written to a single-port-per-direction line store (MAX_LINE_WIDTH
// entries); each lower-row sample of a block reads one entry, so every word
// costs at most one store access and the sustained rate is one word per cycle
// while the output is not stalled. A result word is built from the store's
// registered read and leaves through the output register. o_ready drops only
// while a finished pixel waits in the output register and another one is
// queued behind it. No clearing pass is needed after reset.
module bayer_quad_bin_to_rgb_core #(
    parameter int MAX_LINE_WIDTH = bqb_pkg::DEF_MAX_LINE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bqb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bqb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [15:0]                    i_raw_sample,
    input  logic                           i_start_of_frame,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    output logic                           o_clipped,
    output logic                           o_end_of_row
);
    import bqb_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE_WIDTH);

    // configuration
    logic [1:0]            r_pattern;
    logic                  r_depth;
    logic [CFG_DATA_W-1:0] r_line_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= PAT_RGGB;
            r_depth      <= 1'b0;
            r_line_width <= LINE_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PATTERN: r_pattern    <= i_cfg_data[1:0];
                CFG_DEPTH:   r_depth      <= i_cfg_data[0];
                CFG_WIDTH:   r_line_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic             accept;
    logic [CNT_W-1:0] addr;
    logic             we, re;
    t_entry           s0_entry, rdata;
    t_ctl             s0_ctl;

    assign accept = i_valid && o_ready;

    bqb_sched #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_sched (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_raw_sample     (i_raw_sample),
        .i_start_of_frame (i_start_of_frame),
        .i_depth          (r_depth),
        .i_line_width     (r_line_width),
        .o_addr           (addr),
        .o_we             (we),
        .o_re             (re),
        .o_entry          (s0_entry),
        .o_ctl            (s0_ctl)
    );

    bqb_line_store #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (s0_entry),
        .i_re    (re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // stage 1: store read data lines up with the sample that asked for it
    logic   r_p1_valid;
    t_ctl   r_p1_ctl;
    t_entry r_p1_d;
    t_entry r_a, r_c;
    logic   p1_emit, p1_go;
    t_pix   pix;

    logic       r_out_valid;
    t_pix       r_out_pix;
    logic       r_out_eor;

    assign p1_emit = r_p1_valid && r_p1_ctl.blk && r_p1_ctl.odd;
    assign p1_go   = !p1_emit || !r_out_valid || i_ready;
    // no new read may land while stage 1 still needs the read data
    assign o_ready = !r_p1_valid || p1_go;

    assign pix = combine(r_pattern, r_a, rdata, r_c, r_p1_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else if (o_ready) begin
            r_p1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_ctl <= s0_ctl;
            r_p1_d   <= s0_entry;
        end
    end

    // left column of a lower block: keep upper-left and lower-left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (r_p1_valid && r_p1_ctl.blk && !r_p1_ctl.odd) begin
            r_c <= r_p1_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid && r_p1_ctl.blk && !r_p1_ctl.odd) begin
            r_a <= rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (p1_emit && p1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_emit && p1_go) begin
            r_out_pix <= pix;
            r_out_eor <= r_p1_ctl.eor;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_red        = r_out_pix.red;
    assign o_green      = r_out_pix.green;
    assign o_blue       = r_out_pix.blue;
    assign o_clipped    = r_out_pix.clipped;
    assign o_end_of_row = r_out_eor;

endmodule

[hdl/bqb_checker.sv]
// Port-level checks for the binning core, attached by bind.
// Depends only on the top level's ports.
module bqb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_start_of_frame,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic        o_clipped,
    input logic        o_end_of_row
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue) && $stable(o_clipped) && $stable(o_end_of_row)))
        else $error("result word changed while stalled");

    // a fresh result word comes from an accepted sample, via stage 1 and the output register
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready, 2))
        else $error("result word without a completing sample");

    // input side never stalls unless the output side does
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input stalled with free output");

    // first sample of a frame is an upper-row sample and completes no block
    a_sof_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_start_of_frame) |-> ##2 !$rose(o_valid))
        else $error("result word caused by start of frame sample");

endmodule

bind bayer_quad_bin_to_rgb_core bqb_checker u_bqb_checker (.*);

[verif/bqb_scoreboard_pkg.sv]
// Scoreboard for the Bayer 2x2 binning core: mirrors the block's row and
// column tracking and line store, and queues the expected RGB words.
// Depends on bqb_pkg for register indexes, pattern codes and clip levels.
package bqb_scoreboard_pkg;
    import bqb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       clipped;
        logic       eor;
    } binned_px_t;

    class binning_scoreboard;
        logic [8:0]  upper_line [DEF_MAX_LINE_WIDTH];
        logic [8:0]  lower_left;
        int unsigned col_next;
        bit          in_lower_row;
        logic [1:0]  pattern;
        logic        wide_samples;
        logic [12:0] width_reg;
        binned_px_t  expected_px [$];
        int unsigned words_in;
        int unsigned pixels_checked;
        int unsigned errors;

        function new();
            lower_left     = '0;
            col_next       = 0;
            in_lower_row   = 0;
            pattern        = PAT_RGGB;
            wide_samples   = 1'b0;
            width_reg      = LINE_WIDTH_RST;
            words_in       = 0;
            pixels_checked = 0;
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN: pattern = data[1:0];
                CFG_DEPTH:   wide_samples = data[0];
                CFG_WIDTH:   width_reg = data;
                default: ;
            endcase
        endfunction

        // one accepted raw word; queues a pixel when it closes a 2x2 block
        function void note_word(logic [15:0] raw, logic sof);
            int unsigned w;
            int unsigned even_w;
            int unsigned c;
            logic [8:0]  ent;
            logic [8:0]  a, b, cl, d, r, bl, g1, g2;
            logic [8:0]  gsum;
            binned_px_t  px;

            words_in++;
            w = width_reg;
            if (w < 2) w = 2;
            if (w > DEF_MAX_LINE_WIDTH) w = DEF_MAX_LINE_WIDTH;
            even_w = w - (w % 2);

            if (sof) begin
                col_next     = 0;
                in_lower_row = 0;
            end
            if (col_next >= w) col_next = 0;
            c = col_next;

            if (wide_samples) ent = {raw >= CLIP_16, raw[15:HI_SHIFT]};
            else              ent = {raw[7:0] >= CLIP_8, raw[7:0]};

            if (!in_lower_row) begin
                upper_line[c] = ent;
            end else if (c < even_w) begin
                if (c % 2 == 0) begin
                    lower_left = ent;
                end else begin
                    a  = upper_line[c - 1];
                    b  = upper_line[c];
                    cl = lower_left;
                    d  = ent;
                    case (pattern)
                        PAT_BGGR: begin r = d;  bl = a;  g1 = b; g2 = cl; end
                        PAT_GRBG: begin r = b;  bl = cl; g1 = a; g2 = d;  end
                        PAT_GBRG: begin r = cl; bl = b;  g1 = a; g2 = d;  end
                        default:  begin r = a;  bl = d;  g1 = b; g2 = cl; end
                    endcase
                    gsum = {1'b0, g1[7:0]} + {1'b0, g2[7:0]} + 9'd1;
                    px.red     = r[7:0];
                    px.green   = gsum[8:1];
                    px.blue    = bl[7:0];
                    px.clipped = a[8] | b[8] | cl[8] | d[8];
                    px.eor     = (c == even_w - 1);
                    expected_px.push_back(px);
                end
            end

            if (c + 1 >= w) begin
                col_next     = 0;
                in_lower_row = !in_lower_row;
            end else begin
                col_next = c + 1;
            end
        endfunction

        function void check_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                  logic clipped, logic eor);
            binned_px_t px;
            if (expected_px.size() == 0) begin
                $error("unexpected pixel word: red %0d green %0d blue %0d", red, green, blue);
                errors++;
                return;
            end
            px = expected_px.pop_front();
            pixels_checked++;
            if (red !== px.red) begin
                $error("red: expected %0d, got %0d", px.red, red);
                errors++;
            end
            if (green !== px.green) begin
                $error("green: expected %0d, got %0d", px.green, green);
                errors++;
            end
            if (blue !== px.blue) begin
                $error("blue: expected %0d, got %0d", px.blue, blue);
                errors++;
            end
            if (clipped !== px.clipped) begin
                $error("clipped: expected %0d, got %0d", px.clipped, clipped);
                errors++;
            end
            if (eor !== px.eor) begin
                $error("end_of_row: expected %0d, got %0d", px.eor, eor);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_px.size();
        endfunction
    endclass

endpackage

[verif/bayer_quad_bin_to_rgb_core_test.sv]
// Self-checking bench for bayer_quad_bin_to_rgb_core: directed corner frames,
// then random frames over many register settings with random stalls.
// Depends on bqb_pkg and bqb_scoreboard_pkg.
module bayer_quad_bin_to_rgb_core_test;
    import bqb_pkg::*;
    import bqb_scoreboard_pkg::*;

    // worst case is far below this: ~2.2k words, plus stalls
    localparam int unsigned CYCLE_LIMIT      = 2_000_000;
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_WORDS     = 1550;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [15:0]           i_raw_sample;
    logic                  i_start_of_frame;
    logic                  o_valid;
    logic                  i_ready;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic                  o_clipped;
    logic                  o_end_of_row;

    binning_scoreboard sb = new();

    bit          tx_idle;
    bit          rx_idle;
    bit          long_hold;
    int unsigned cycles;
    int unsigned settings_used;
    int unsigned frames_sent;

    bayer_quad_bin_to_rgb_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_raw_sample     (i_raw_sample),
        .i_start_of_frame (i_start_of_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_clipped        (o_clipped),
        .o_end_of_row     (o_end_of_row)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timed out after %0d cycles, %0d pixels still expected", cycles, sb.pending());
        $display("bayer_quad_bin_to_rgb_core: mismatch");
        $finish;
    end

    // output side: random stall bursts, plus one long hold-off on request
    initial begin
        int unsigned k;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                for (k = 0; k < LONG_HOLD_CYCLES; k++) @(posedge i_clk);
                long_hold = 0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_pixel(o_red, o_green, o_blue, o_clipped, o_end_of_row);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // unused upper data bits carry junk on the narrow registers
    task automatic program_block(logic [1:0] pat, logic depth, logic [12:0] width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_PATTERN, {junk[12:2], pat});
        write_reg(CFG_DEPTH, {junk[12:1], depth});
        write_reg(CFG_WIDTH, width);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_word(logic [15:0] raw, logic sof);
        i_valid          <= 1'b1;
        i_raw_sample     <= raw;
        i_start_of_frame <= sof;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(raw, sof);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            i_valid          <= 1'b0;
            i_raw_sample     <= 16'($urandom);
            i_start_of_frame <= 1'($urandom);
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // block goes idle: all pixels out, then a drain wait for in-flight words
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // biased toward both clip thresholds and their neighbors
    function automatic logic [15:0] rand_sample();
        logic [15:0] s;
        s = 16'($urandom);
        case ($urandom_range(0, 9))
            0: s[7:0] = 8'hFF;
            1: s[7:0] = 8'hFE;
            2: s[15:3] = 13'h1FFF;
            3: s = 16'hFFF7;
            4: s = 16'h0000;
            default: ;
        endcase
        return s;
    endfunction

    task automatic send_frames(int unsigned count, int unsigned frame_len, bit noisy);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % frame_len == 0) frames_sent++;
            send_word(rand_sample(),
                      (i % frame_len == 0) || (noisy && $urandom_range(0, 30) == 0));
        end
    endtask

    initial begin
        logic [12:0] wreg;
        logic [1:0]  pat;
        logic        depth;
        bit          noisy;
        int unsigned eff_w, rows, count, frame_len, random_words, phase;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_PATTERN;
        i_cfg_data       <= '0;
        i_valid          <= 1'b0;
        i_raw_sample     <= '0;
        i_start_of_frame <= 1'b0;
        tx_idle       = 1;
        rx_idle       = 1;
        long_hold     = 0;
        settings_used = 0;
        frames_sent   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 8-bit: clip at 255 with junk high byte, high byte ignored
        program_block(PAT_RGGB, 1'b0, 13'd2);
        send_word(16'h12FF, 1'b1);
        send_word(16'h00FE, 1'b0);
        send_word(16'hFF00, 1'b0);
        send_word(16'h0001, 1'b0);
        settle();

        // 16-bit, width 0 clamps to 2: clip threshold 65528 and just below
        program_block(PAT_BGGR, 1'b1, 13'd0);
        send_word(16'hFFF8, 1'b1);
        send_word(16'hFFF7, 1'b0);
        send_word(16'h00FF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFF7, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0100, 1'b0);
        send_word(16'h7FFF, 1'b0);
        settle();

        // width 1 clamps to 2
        program_block(PAT_GRBG, 1'b0, 13'd1);
        send_word(16'h0000, 1'b1);
        send_word(16'h00FF, 1'b0);
        send_word(16'h0080, 1'b0);
        send_word(16'h0001, 1'b0);
        settle();

        // odd width: last column stored, never binned; then an upper row with no partner
        program_block(PAT_GBRG, 1'b1, 13'd3);
        send_word(16'h1234, 1'b1);
        send_word(16'hABCD, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h5600, 1'b0);
        send_word(16'hFE00, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'hFFFF, 1'b0);
        settle();

        // width shrinks in the middle of a lower row: column wraps, row stays lower
        program_block(PAT_RGGB, 1'b0, 13'd4);
        send_word(16'h0010, 1'b1);
        send_word(16'h0020, 1'b0);
        send_word(16'h0030, 1'b0);
        send_word(16'h0040, 1'b0);
        send_word(16'h0050, 1'b0);
        send_word(16'h0060, 1'b0);
        settle();
        program_block(PAT_RGGB, 1'b0, 13'd2);
        send_word(16'h00F0, 1'b0);
        send_word(16'h00FF, 1'b0);
        settle();

        random_words = 0;
        phase        = 0;
        while (random_words < RANDOM_WORDS) begin
            pat   = 2'($urandom);
            depth = 1'($urandom);
            case ($urandom_range(0, 19))
                0:          wreg = 13'($urandom_range(0, 1));
                1, 2, 3, 4: wreg = 13'($urandom_range(17, 80));
                default:    wreg = 13'($urandom_range(2, 16));
            endcase
            eff_w   = (wreg < 2) ? 2 : wreg;
            rows    = (eff_w > 16) ? $urandom_range(2, 3) : $urandom_range(2, 6);
            frame_len = rows * eff_w;
            count   = ((eff_w > 16) ? 1 : $urandom_range(1, 3)) * frame_len;
            noisy   = ($urandom_range(0, 3) == 0);
            if (noisy) count = $urandom_range(eff_w, count);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);

            if (phase == 4) begin
                // output held off while input keeps coming: fills the block
                wreg = 13'd4;
                frame_len = 16;
                count = 256;
                noisy = 0;
                tx_idle = 0;
                long_hold = 1;
            end

            program_block(pat, depth, wreg);
            send_frames(count, frame_len, noisy);
            settle();
            random_words += count;
            phase++;
        end

        // closing stretch at full rate on both sides
        tx_idle = 0;
        rx_idle = 0;
        repeat (2) begin
            wreg = 13'($urandom_range(2, 16));
            program_block(2'($urandom), 1'($urandom), wreg);
            send_frames(120, 4 * wreg, 0);
            settle();
        end

        $display("%0d raw words in %0d frames over %0d register settings",
                 sb.words_in, frames_sent, settings_used);
        $display("%0d binned pixels checked, %0d field errors", sb.pixels_checked, sb.errors);
        if (sb.errors == 0)
            $display("bayer_quad_bin_to_rgb_core: match");
        else
            $display("bayer_quad_bin_to_rgb_core: mismatch");
        $finish;
    end

endmodule
